@@ src/tap_tempo_lfo_phase_core_assert.svh @@
// Assertion macros shared by the tap tempo LFO phase core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TAP_TEMPO_LFO_PHASE_CORE_ASSERT_SVH
`define TAP_TEMPO_LFO_PHASE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TTLFO_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define TTLFO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define TTLFO_ASSERT_SAME(lbl, ante, cons)
`define TTLFO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/tt_lfo_pkg.sv @@
package tt_lfo_pkg;

	// Item kinds carried in the opcode field.
	localparam logic OP_TAP   = 1'b0;
	localparam logic OP_TEMPO = 1'b1;

	// Tap machine gives up after this many sample ticks.
	localparam int TAP_TIMEOUT = 8192;

	// Debounce history patterns for a stable press and a stable release.
	localparam logic [7:0] HIST_PRESSED  = 8'hff;
	localparam logic [7:0] HIST_RELEASED = 8'h00;

	// Knob thresholds that select the note multiplier.
	localparam logic [7:0] KNOB_TH_16 = 8'd25;
	localparam logic [7:0] KNOB_TH_8  = 8'd76;
	localparam logic [7:0] KNOB_TH_4  = 8'd127;
	localparam logic [7:0] KNOB_TH_3  = 8'd178;
	localparam logic [7:0] KNOB_TH_2  = 8'd229;

	// Result of one tap sample tick, plus the machine's busy flag.
	typedef struct packed {
		logic        sync;
		logic        period_valid;
		logic [15:0] period;
		logic        busy;
	} tap_res_t;

	// Map a knob position to the number of tempo ticks per phase step.
	function automatic logic [4:0] knob_to_mult(input logic [7:0] knob);
		logic [4:0] mult;
		if (knob < KNOB_TH_16) begin
			mult = 5'd16;
		end else if (knob < KNOB_TH_8) begin
			mult = 5'd8;
		end else if (knob < KNOB_TH_4) begin
			mult = 5'd4;
		end else if (knob < KNOB_TH_3) begin
			mult = 5'd3;
		end else if (knob < KNOB_TH_2) begin
			mult = 5'd2;
		end else begin
			mult = 5'd1;
		end
		return mult;
	endfunction

endpackage

@@ src/tt_lfo_if.sv @@
// Input channel: one tick item.
interface tt_lfo_tick_if;
	logic valid;
	logic ready;
	logic opcode;
	logic button_pressed;

	modport source (output valid, output opcode, output button_pressed, input ready);
	modport sink   (input valid, input opcode, input button_pressed, output ready);
endinterface

// Output channel: one result item.
interface tt_lfo_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  lfo_phase_out;
	logic        beat_led;
	logic        sync_pulse;
	logic        period_valid;
	logic [15:0] tempo_period;

	modport source (
		output valid, output lfo_phase_out, output beat_led, output sync_pulse,
		output period_valid, output tempo_period, input ready
	);
	modport sink (
		input valid, input lfo_phase_out, input beat_led, input sync_pulse,
		input period_valid, input tempo_period, output ready
	);
endinterface

@@ src/tt_lfo_tap.sv @@
module tt_lfo_tap (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_en,
	input  logic                button,
	output tt_lfo_pkg::tap_res_t res
);
	import tt_lfo_pkg::*;

	// Tap machine states.
	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_PRESS1   = 2'd1;
	localparam logic [1:0] ST_RELEASE1 = 2'd2;
	localparam logic [1:0] ST_PRESS2   = 2'd3;

	logic [7:0]  hist_q;
	logic [15:0] count_q;
	logic [1:0]  state_q;

	logic [7:0]  hist_n;
	logic [15:0] count_inc;
	logic [15:0] count_n;
	logic [1:0]  state_eff;
	logic [1:0]  state_n;
	logic        sync;
	logic        pvalid;

	// Next values for a sample tick, with the timeout applied before the state check.
	always_comb begin
		hist_n    = {hist_q[6:0], button};
		count_inc = count_q + 16'd1;
		count_n   = count_inc;
		state_eff = state_q;
		if ((state_q != ST_IDLE) && (count_inc >= 16'(TAP_TIMEOUT))) begin
			state_eff = ST_IDLE;
		end
		state_n = state_eff;
		sync    = 1'b0;
		pvalid  = 1'b0;
		case (state_eff)
			ST_IDLE: begin
				if (hist_n == HIST_PRESSED) begin
					count_n = '0;
					state_n = ST_PRESS1;
					sync    = 1'b1;
				end
			end
			ST_PRESS1: begin
				if (hist_n == HIST_RELEASED) begin
					state_n = ST_RELEASE1;
				end
			end
			ST_RELEASE1: begin
				if (hist_n == HIST_PRESSED) begin
					state_n = ST_PRESS2;
					pvalid  = 1'b1;
				end
			end
			default: begin
				if (hist_n == HIST_RELEASED) begin
					state_n = ST_IDLE;
				end
			end
		endcase
	end

	// The period is the tick count times eight, truncated to 16 bits.
	always_comb begin
		res.sync         = sync;
		res.period_valid = pvalid;
		res.period       = pvalid ? {count_inc[12:0], 3'b000} : 16'd0;
		res.busy         = (state_q != ST_IDLE);
	end

	// Tap state advances only on an accepted sample tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			count_q <= '0;
			state_q <= ST_IDLE;
		end else if (tick_en) begin
			hist_q  <= hist_n;
			count_q <= count_n;
			state_q <= state_n;
		end
	end

endmodule

@@ src/tap_tempo_lfo_phase_core.sv @@
// Channel    Dir  Payload                                               Handshake
// tick_in    in   opcode, button_pressed                                valid/ready
// result_out out  lfo_phase_out, beat_led, sync_pulse, period_valid,    valid/ready
//                 tempo_period
// cfg        in   cfg_wdata (note_knob)                                 cfg_we, no wait
//
// One item per clock sustained while result_out does not stall; each item passes
// through the input register and then waits in the result register until taken.
// All tick work is a single pass of counter, shift and compare logic.
// arst_n clears valid, tap and phase state asynchronously; note multiplier resets to 16.
// When result_out stalls, the input register fills and tick_in.ready drops.
module tap_tempo_lfo_phase_core (
	input  logic              clk,
	input  logic              arst_n,
	tt_lfo_tick_if.sink       tick_in,
	tt_lfo_res_if.source      result_out,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);
	import tt_lfo_pkg::*;

	// Input register.
	logic valid_s1;
	logic opcode_s1;
	logic button_s1;

	// Phase state.
	logic [4:0] mult_q;
	logic [7:0] mod_phase_q;
	logic [4:0] lfo_div_q;
	logic [9:0] beat_phase_q;

	// Result register.
	logic        out_valid_q;
	logic [7:0]  out_phase_q;
	logic        out_led_q;
	logic        out_sync_q;
	logic        out_pvalid_q;
	logic [15:0] out_period_q;

	logic       adv;
	logic       is_tempo;
	logic       tap_en;
	tap_res_t   tap_res;
	logic [4:0] div_inc;
	logic       step;
	logic       led;

	// Stage 1 moves on whenever the result register is free or being emptied.
	assign adv           = valid_s1 && (!out_valid_q || result_out.ready);
	assign tick_in.ready = !valid_s1 || adv;
	assign is_tempo      = (opcode_s1 == OP_TEMPO);
	assign tap_en        = adv && !is_tempo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_in.ready) begin
			valid_s1 <= tick_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.ready && tick_in.valid) begin
			opcode_s1 <= tick_in.opcode;
			button_s1 <= tick_in.button_pressed;
		end
	end

	tt_lfo_tap u_tap (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_en (tap_en),
		.button  (button_s1),
		.res     (tap_res)
	);

	// Tempo tick arithmetic.
	assign div_inc = lfo_div_q + 5'd1;
	assign step    = (div_inc >= mult_q);
	assign led     = (beat_phase_q[9:8] == 2'b00) || tap_res.busy;

	// Note multiplier follows the knob register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= knob_to_mult(8'd0);
		end else if (cfg_we) begin
			mult_q <= knob_to_mult(cfg_wdata);
		end
	end

	// Phases clear on a knob write or a re-sync, and advance on tempo ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_phase_q  <= '0;
			lfo_div_q    <= '0;
			beat_phase_q <= '0;
		end else if (cfg_we) begin
			mod_phase_q  <= '0;
			lfo_div_q    <= '0;
			beat_phase_q <= '0;
		end else if (adv) begin
			if (is_tempo) begin
				beat_phase_q <= beat_phase_q + 10'd1;
				if (step) begin
					mod_phase_q <= mod_phase_q + 8'd1;
					lfo_div_q   <= '0;
				end else begin
					lfo_div_q <= div_inc;
				end
			end else if (tap_res.sync) begin
				mod_phase_q  <= '0;
				lfo_div_q    <= '0;
				beat_phase_q <= '0;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; a tap tick reports the phase after any re-sync.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_tempo) begin
				out_phase_q  <= mod_phase_q;
				out_led_q    <= led;
				out_sync_q   <= 1'b0;
				out_pvalid_q <= 1'b0;
				out_period_q <= '0;
			end else begin
				out_phase_q  <= tap_res.sync ? 8'd0 : mod_phase_q;
				out_led_q    <= 1'b0;
				out_sync_q   <= tap_res.sync;
				out_pvalid_q <= tap_res.period_valid;
				out_period_q <= tap_res.period;
			end
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.lfo_phase_out = out_phase_q;
	assign result_out.beat_led      = out_led_q;
	assign result_out.sync_pulse    = out_sync_q;
	assign result_out.period_valid  = out_pvalid_q;
	assign result_out.tempo_period  = out_period_q;

`include "tap_tempo_lfo_phase_core_assert.svh"

	// A re-sync and a new period never come from the same tick.
	`TTLFO_ASSERT_SAME(a_sync_pvalid_excl, out_valid_q, !(out_sync_q && out_pvalid_q))
	// A period is reported only together with its valid flag.
	`TTLFO_ASSERT_SAME(a_period_gated, out_valid_q && !out_pvalid_q, out_period_q == 16'd0)
	// A knob write leaves the LFO phase at zero.
	`TTLFO_ASSERT_NEXT(a_cfg_clears, cfg_we, mod_phase_q == 8'd0 && beat_phase_q == 10'd0)
	// A held item in stage 1 reaches an empty result register in the next cycle.
	`TTLFO_ASSERT_NEXT(a_stage_moves, valid_s1 && !out_valid_q, out_valid_q)

endmodule
